FILE: hdl/dnsx_pkg.sv
// Shared beat types and constants for the DNS answer address-record extractor.
package dnsx_pkg;

	localparam logic [7:0]  PTR_MARK = 8'hC0;
	localparam logic [15:0] TYPE_A   = 16'd1;
	localparam logic [15:0] A_RDLEN  = 16'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic        record_valid;
		logic [31:0] address;
		logic [15:0] record_class;
		logic [31:0] ttl_seconds;
		logic        message_done;
		logic        malformed;
	} out_beat_t;

endpackage

FILE: hdl/dnsx_parser.sv
// Byte-at-a-time DNS response parser: walks header, question and records.
module dnsx_parser
	import dnsx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_beat_t  beat,
	input  logic      prefix_en,
	output logic      res_valid,
	output out_beat_t res
);

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_PREFIX = 4'd1,
		PH_HEADER = 4'd2,
		PH_QNAME  = 4'd3,
		PH_QLABEL = 4'd4,
		PH_QPTR   = 4'd5,
		PH_QTAIL  = 4'd6,
		PH_NAME   = 4'd7,
		PH_LABEL  = 4'd8,
		PH_PTR    = 4'd9,
		PH_FIXED  = 4'd10,
		PH_ADDR   = 4'd11,
		PH_SKIP   = 4'd12,
		PH_DONE   = 4'd13
	} phase_t;

	phase_t      phase_q, n_phase, ph;
	logic [15:0] fc_q, n_fc, fc;
	logic [16:0] rl_q, n_rl, rl_dec;
	logic [7:0]  label_q, n_label;
	logic [31:0] shift_q, sw;
	logic [15:0] type_q, n_type;
	logic [15:0] class_q, n_class;
	logic [31:0] ttl_q, n_ttl;
	logic        err_q, n_err;
	logic        emit;
	logic [31:0] addr;
	logic [15:0] rdlen;

	// Work out the next parser state for the incoming byte
	always_comb begin
		ph = phase_q;
		fc = fc_q;
		if (phase_q == PH_START) begin
			ph = prefix_en ? PH_PREFIX : PH_HEADER;
			fc = '0;
		end
		sw      = {shift_q[23:0], beat.data_byte};
		rdlen   = sw[15:0];
		rl_dec  = (rl_q != '0) ? rl_q - 17'd1 : '0;
		n_phase = ph;
		n_fc    = fc;
		n_rl    = rl_q;
		n_label = label_q;
		n_type  = type_q;
		n_class = class_q;
		n_ttl   = ttl_q;
		n_err   = err_q;
		emit    = 1'b0;
		addr    = '0;
		case (ph)
			PH_PREFIX: begin
				n_fc = fc + 16'd1;
				if (fc >= 16'd1) begin
					n_fc    = '0;
					n_phase = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (fc == 16'd7)
					n_rl = {1'b0, sw[15:0]};
				else if (fc == 16'd9)
					n_rl = rl_q + {1'b0, sw[15:0]};
				n_fc = fc + 16'd1;
				if (fc >= 16'd11) begin
					n_fc    = '0;
					n_phase = PH_QNAME;
				end
			end
			PH_QNAME, PH_NAME: begin
				if ((beat.data_byte & PTR_MARK) == PTR_MARK) begin
					n_phase = (ph == PH_QNAME) ? PH_QPTR : PH_PTR;
				end else if (beat.data_byte == 8'd0) begin
					n_fc    = '0;
					n_phase = (ph == PH_QNAME) ? PH_QTAIL : PH_FIXED;
				end else begin
					n_label = beat.data_byte;
					n_phase = (ph == PH_QNAME) ? PH_QLABEL : PH_LABEL;
				end
			end
			PH_QLABEL, PH_LABEL: begin
				n_label = label_q - 8'd1;
				if (n_label == 8'd0)
					n_phase = (ph == PH_QLABEL) ? PH_QNAME : PH_NAME;
			end
			PH_QPTR: begin
				n_fc    = '0;
				n_phase = PH_QTAIL;
			end
			PH_PTR: begin
				n_fc    = '0;
				n_phase = PH_FIXED;
			end
			PH_QTAIL: begin
				n_fc = fc + 16'd1;
				if (fc >= 16'd3) begin
					n_fc    = '0;
					n_phase = (rl_q != '0) ? PH_NAME : PH_DONE;
				end
			end
			PH_FIXED: begin
				if (fc == 16'd1)
					n_type = sw[15:0];
				else if (fc == 16'd3)
					n_class = sw[15:0];
				else if (fc == 16'd7)
					n_ttl = sw;
				n_fc = fc + 16'd1;
				if (fc >= 16'd9) begin
					n_fc = '0;
					if (type_q == TYPE_A && rdlen == A_RDLEN) begin
						n_phase = PH_ADDR;
					end else begin
						if (type_q == TYPE_A)
							n_err = 1'b1;
						if (rdlen == 16'd0) begin
							n_rl    = rl_dec;
							n_phase = (rl_dec != '0) ? PH_NAME : PH_DONE;
						end else begin
							n_fc    = rdlen;
							n_phase = PH_SKIP;
						end
					end
				end
			end
			PH_ADDR: begin
				n_fc = fc + 16'd1;
				if (fc >= 16'd3) begin
					emit    = 1'b1;
					addr    = sw;
					n_fc    = '0;
					n_rl    = rl_dec;
					n_phase = (rl_dec != '0) ? PH_NAME : PH_DONE;
				end
			end
			PH_SKIP: begin
				if (fc != '0)
					n_fc = fc - 16'd1;
				if (n_fc == '0) begin
					n_rl    = rl_dec;
					n_phase = (rl_dec != '0) ? PH_NAME : PH_DONE;
				end
			end
			default: begin
				n_phase = PH_DONE;
			end
		endcase
	end

	// Build the result beat from the updated state
	always_comb begin
		res_valid        = fire && (emit || beat.last_byte);
		res.record_valid = emit;
		res.address      = emit ? addr : '0;
		res.record_class = emit ? n_class : '0;
		res.ttl_seconds  = emit ? n_ttl : '0;
		res.message_done = beat.last_byte;
		res.malformed    = n_err || (beat.last_byte && n_phase != PH_DONE);
	end

	// Advance on each accepted byte; return to message start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			fc_q    <= '0;
			rl_q    <= '0;
			label_q <= '0;
			shift_q <= '0;
			type_q  <= '0;
			class_q <= '0;
			ttl_q   <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			if (beat.last_byte) begin
				phase_q <= PH_START;
				fc_q    <= '0;
				rl_q    <= '0;
				label_q <= '0;
				shift_q <= '0;
				type_q  <= '0;
				class_q <= '0;
				ttl_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= n_phase;
				fc_q    <= n_fc;
				rl_q    <= n_rl;
				label_q <= n_label;
				shift_q <= sw;
				type_q  <= n_type;
				class_q <= n_class;
				ttl_q   <= n_ttl;
				err_q   <= n_err;
			end
		end
	end

	// A finished message always leaves the parser at message start
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat.last_byte |=> phase_q == PH_START && !err_q)
		else $error("parser not cleared after last byte");

	// Error flag only sets while a record's fixed fields are being read
	a_err_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> $past(phase_q) == PH_FIXED)
		else $error("error flag set outside fixed fields");

	// An address record is emitted only when the held type is an A record
	a_emit_type: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |-> type_q == TYPE_A && phase_q == PH_ADDR)
		else $error("address emitted without A record");

endmodule

FILE: hdl/dnsx_out_buf.sv
// Two-entry result buffer that decouples the parser from the result receiver.
module dnsx_out_buf
	import dnsx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_beat_t push_data,
	output logic      has_room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	out_beat_t   mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign has_room  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Never push into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> has_room)
		else $error("push into full result buffer");

	// Fill level stays within two entries
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	// Pointers differ exactly when one beat is held
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q != rd_ptr_q) == (count_q == 2'd1))
		else $error("result buffer pointers disagree with count");

endmodule

FILE: hdl/dns_answer_a_record_extractor_core.sv
// Top level of the DNS answer address-record extractor.
//
// Input channel (in_valid/in_ready/in_data): one DNS message byte per beat,
// with last_byte set on the final byte. With cfg_data set to 1 the first two
// bytes of each message are taken as a TCP length prefix and skipped.
// Output channel (out_valid/out_ready/out_data): one beat per A record with
// rdlength 4 in the answer and authority sections, plus one beat for the
// last byte of every message carrying message_done and the malformed flag.
// A record found on the last byte shares that one beat.
// Config channel (cfg_valid/cfg_ready/cfg_data) is always ready; the prefix
// setting is sampled at the first byte of each message.
// Throughput: one byte per cycle while in_ready is high, as the parser advances on every accepted byte.
// A result is written into the result buffer with its byte and can reach out_valid in the cycle after.
// A two-entry result buffer lets the parser keep accepting bytes while a
// result waits; in_ready drops only when both entries are held, that is
// when the receiver stalls across two results.
// Reset: the parser returns to message start, the buffer empties and the
// prefix setting clears to 0.
module dns_answer_a_record_extractor_core
	import dnsx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic      prefix_q;
	logic      fire;
	logic      res_valid;
	out_beat_t res;
	logic      has_room;

	assign cfg_ready = 1'b1;
	assign in_ready  = has_room;
	assign fire      = in_valid && in_ready;

	// Hold the prefix setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prefix_q <= 1'b0;
		else if (cfg_valid && cfg_ready)
			prefix_q <= cfg_data;
	end

	dnsx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.beat      (in_data),
		.prefix_en (prefix_q),
		.res_valid (res_valid),
		.res       (res)
	);

	dnsx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
